// ===== rtl/core/stl_pkg.sv =====
// Shared types, codes and defaults for the session table core.
// No dependencies; used by stl_age_cmp and session_table_ttl_lru_core.
package stl_pkg;

	localparam int unsigned SESSIONS_DEF         = 256;
	localparam int unsigned KEYS_PER_SESSION_DEF = 16;
	localparam int unsigned TAG_BITS_DEF         = 64;
	localparam int unsigned VALUE_BITS_DEF       = 64;
	localparam logic [31:0] TTL_RESET            = 32'd43200;

	localparam logic [2:0] ACT_SET_KEY   = 3'd0;
	localparam logic [2:0] ACT_SET_TOKEN = 3'd1;
	localparam logic [2:0] ACT_GET_KEY   = 3'd2;
	localparam logic [2:0] ACT_GET_TOKEN = 3'd3;
	localparam logic [2:0] ACT_CLEAR     = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_CAP   = 2'd2;
	localparam logic [1:0] ST_MISS  = 2'd3;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] now;
		logic [63:0] session_tag;
		logic [63:0] agent_tag;
		logic [63:0] key_value;
		logic [63:0] token_value;
		logic [63:0] account_value;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [63:0] key_out;
		logic [63:0] token_out;
		logic [63:0] account_out;
		logic [1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic expired;
		logic older;
	} cmp_t;

endpackage

// ===== rtl/core/stl_age_cmp.sv =====
// Shared time compare unit: idle expiry against the TTL and recency order.
// Depends on stl_pkg.
module stl_age_cmp (
	input  logic [31:0]   now,
	input  logic [31:0]   last,
	input  logic [31:0]   ttl,
	input  logic [31:0]   best,
	input  logic          have_best,
	output stl_pkg::cmp_t res
);

	logic [33:0] idle;

	assign idle = {2'b00, now} - {2'b00, last};

	always_comb begin
		res.expired = $signed(idle) > $signed({2'b00, ttl});
		res.older   = !have_best || (last < best);
	end

endmodule

// ===== rtl/core/session_table_ttl_lru_core.sv =====
// Session table with idle aging and LRU replacement, top level.
// Depends on stl_pkg and stl_age_cmp.
//
//  channel | signals                       | direction | transfer
//  req     | req_valid, req_stall, req     | in        | valid & !stall
//  rsp     | rsp_valid, rsp_stall, rsp     | out       | valid & !stall
//  cfg     | ttl_wr_en, ttl_wr_data        | in        | wr_en, no wait
//
// A transaction scans the slots through the slot memory and the age compare unit until
// a hit or the last slot, then searches key entries and moves entries in compaction.
// Reset clears the valid bits and the sequencer; no clearing pass.
// A new request is taken while a finished response waits under rsp_stall.
module session_table_ttl_lru_core #(
	parameter int unsigned SESSIONS         = stl_pkg::SESSIONS_DEF,
	parameter int unsigned KEYS_PER_SESSION = stl_pkg::KEYS_PER_SESSION_DEF,
	parameter int unsigned TAG_BITS         = stl_pkg::TAG_BITS_DEF,
	parameter int unsigned VALUE_BITS       = stl_pkg::VALUE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  stl_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output stl_pkg::rsp_t rsp,
	input  logic          ttl_wr_en,
	input  logic [31:0]   ttl_wr_data
);

	localparam int unsigned SW   = $clog2(SESSIONS);
	localparam int unsigned CW   = $clog2(KEYS_PER_SESSION + 1);
	localparam int unsigned EAW  = $clog2(SESSIONS * KEYS_PER_SESSION);
	localparam int unsigned EDEP = SESSIONS * KEYS_PER_SESSION;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_SRD  = 10'b0000000010,
		S_SCHK = 10'b0000000100,
		S_MISS = 10'b0000001000,
		S_ERD  = 10'b0000010000,
		S_ECHK = 10'b0000100000,
		S_CRD  = 10'b0001000000,
		S_CWR  = 10'b0010000000,
		S_SWR  = 10'b0100000000,
		S_DONE = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [31:0]           ttl_q;
	logic [2:0]            act_q;
	logic [31:0]           now_q;
	logic [TAG_BITS-1:0]   sess_q;
	logic [TAG_BITS-1:0]   agent_q;
	logic [VALUE_BITS-1:0] key_q;
	logic [VALUE_BITS-1:0] tokin_q;
	logic [VALUE_BITS-1:0] accin_q;

	logic [SESSIONS-1:0]   valid_q;
	logic [SW-1:0]         idx_q;
	logic                  have_free_q;
	logic [SW-1:0]         free_idx_q;
	logic                  have_lru_q;
	logic [SW-1:0]         lru_idx_q;
	logic [31:0]           lru_time_q;

	logic [SW-1:0]         slot_q;
	logic [CW-1:0]         cnt_q;
	logic [VALUE_BITS-1:0] tok_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic [CW-1:0]         ent_i_q;

	logic                  r_found_q;
	logic [VALUE_BITS-1:0] r_key_q;
	logic [VALUE_BITS-1:0] r_tok_q;
	logic [VALUE_BITS-1:0] r_acc_q;
	logic [1:0]            r_status_q;

	logic [TAG_BITS-1:0]   slot_tag_mem  [SESSIONS];
	logic [31:0]           slot_time_mem [SESSIONS];
	logic [CW-1:0]         slot_cnt_mem  [SESSIONS];
	logic [VALUE_BITS-1:0] slot_tok_mem  [SESSIONS];
	logic [VALUE_BITS-1:0] slot_acc_mem  [SESSIONS];
	logic [TAG_BITS-1:0]   ent_agent_mem [EDEP];
	logic [VALUE_BITS-1:0] ent_key_mem   [EDEP];

	logic [TAG_BITS-1:0]   rd_tag;
	logic [31:0]           rd_time;
	logic [CW-1:0]         rd_cnt;
	logic [VALUE_BITS-1:0] rd_tok;
	logic [VALUE_BITS-1:0] rd_acc;
	logic [TAG_BITS-1:0]   rd_agent;
	logic [VALUE_BITS-1:0] rd_key;

	logic [EAW-1:0]        ent_base;
	logic [EAW-1:0]        ent_waddr;
	logic [EAW-1:0]        ent_raddr;
	logic                  ent_we;
	logic [TAG_BITS-1:0]   ent_wagent;
	logic [VALUE_BITS-1:0] ent_wkey;
	logic                  last_slot;
	logic                  ent_match;
	logic                  key_zero;
	logic [CW-1:0]         ent_next;
	stl_pkg::cmp_t         cmp;

	stl_age_cmp u_cmp (
		.now       (now_q),
		.last      (rd_time),
		.ttl       (ttl_q),
		.best      (lru_time_q),
		.have_best (have_lru_q),
		.res       (cmp)
	);

	assign req_stall = (state_q != S_IDLE);
	assign last_slot = (idx_q == SW'(SESSIONS - 1));
	assign key_zero  = (key_q == '0);
	assign ent_next  = ent_i_q + CW'(1);
	assign ent_base  = EAW'(slot_q) * EAW'(KEYS_PER_SESSION);
	assign ent_waddr = ent_base + EAW'(ent_i_q);
	assign ent_raddr = (state_q == S_CRD) ? ent_base + EAW'(ent_next) : ent_waddr;
	assign ent_match = (rd_agent == agent_q) &&
		((act_q != stl_pkg::ACT_GET_KEY) || (rd_key != '0));

	always_comb begin
		ent_we     = 1'b0;
		ent_wagent = agent_q;
		ent_wkey   = key_q;
		case (state_q)
			S_ERD: begin
				ent_we = (ent_i_q == cnt_q) && (act_q == stl_pkg::ACT_SET_KEY) && !key_zero &&
					(cnt_q < CW'(KEYS_PER_SESSION));
			end
			S_ECHK: begin
				ent_we = ent_match && (act_q == stl_pkg::ACT_SET_KEY) && !key_zero;
			end
			S_CWR: begin
				ent_we     = 1'b1;
				ent_wagent = rd_agent;
				ent_wkey   = rd_key;
			end
			default: begin
				ent_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		rd_tag   <= slot_tag_mem[idx_q];
		rd_time  <= slot_time_mem[idx_q];
		rd_cnt   <= slot_cnt_mem[idx_q];
		rd_tok   <= slot_tok_mem[idx_q];
		rd_acc   <= slot_acc_mem[idx_q];
		rd_agent <= ent_agent_mem[ent_raddr];
		rd_key   <= ent_key_mem[ent_raddr];
		if (state_q == S_SWR) begin
			slot_tag_mem[slot_q]  <= sess_q;
			slot_time_mem[slot_q] <= now_q;
			slot_cnt_mem[slot_q]  <= cnt_q;
			slot_tok_mem[slot_q]  <= tok_q;
			slot_acc_mem[slot_q]  <= acc_q;
		end
		if (ent_we) begin
			ent_agent_mem[ent_waddr] <= ent_wagent;
			ent_key_mem[ent_waddr]   <= ent_wkey;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q <= stl_pkg::TTL_RESET;
		end else if (ttl_wr_en) begin
			ttl_q <= ttl_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				act_q       <= req.action;
				now_q       <= req.now;
				sess_q      <= req.session_tag[TAG_BITS-1:0];
				agent_q     <= req.agent_tag[TAG_BITS-1:0];
				key_q       <= req.key_value[VALUE_BITS-1:0];
				tokin_q     <= req.token_value[VALUE_BITS-1:0];
				accin_q     <= req.account_value[VALUE_BITS-1:0];
				have_free_q <= 1'b0;
				have_lru_q  <= 1'b0;
				r_found_q   <= 1'b0;
				r_key_q     <= '0;
				r_tok_q     <= '0;
				r_acc_q     <= '0;
				if (req.action > stl_pkg::ACT_CLEAR) begin
					r_status_q <= stl_pkg::ST_MISS;
				end else if ((req.session_tag[TAG_BITS-1:0] == '0) ||
					(((req.action == stl_pkg::ACT_SET_KEY) ||
					(req.action == stl_pkg::ACT_GET_KEY)) &&
					(req.agent_tag[TAG_BITS-1:0] == '0))) begin
					r_status_q <= stl_pkg::ST_EMPTY;
				end else begin
					r_status_q <= stl_pkg::ST_OK;
				end
			end
			S_SRD: begin
				if (!valid_q[idx_q] && !have_free_q) begin
					have_free_q <= 1'b1;
					free_idx_q  <= idx_q;
				end
			end
			S_SCHK: begin
				if (cmp.expired) begin
					if (!have_free_q) begin
						have_free_q <= 1'b1;
						free_idx_q  <= idx_q;
					end
				end else if (rd_tag == sess_q) begin
					slot_q  <= idx_q;
					cnt_q   <= rd_cnt;
					tok_q   <= (act_q == stl_pkg::ACT_SET_TOKEN) ? tokin_q : rd_tok;
					acc_q   <= (act_q == stl_pkg::ACT_SET_TOKEN) ? accin_q : rd_acc;
					ent_i_q <= '0;
					case (act_q)
						stl_pkg::ACT_GET_TOKEN: begin
							if (rd_tok != '0) begin
								r_found_q <= 1'b1;
								r_tok_q   <= rd_tok;
								r_acc_q   <= rd_acc;
							end else begin
								r_status_q <= stl_pkg::ST_MISS;
							end
						end
						default: begin
							r_status_q <= r_status_q;
						end
					endcase
				end else if (cmp.older) begin
					have_lru_q <= 1'b1;
					lru_idx_q  <= idx_q;
					lru_time_q <= rd_time;
				end
			end
			S_MISS: begin
				slot_q  <= have_free_q ? free_idx_q : lru_idx_q;
				cnt_q   <= '0;
				ent_i_q <= '0;
				if (act_q == stl_pkg::ACT_SET_TOKEN) begin
					tok_q <= tokin_q;
					acc_q <= accin_q;
				end else begin
					tok_q <= '0;
					acc_q <= '0;
				end
				if ((act_q != stl_pkg::ACT_SET_KEY) && (act_q != stl_pkg::ACT_SET_TOKEN)) begin
					r_status_q <= stl_pkg::ST_MISS;
				end
			end
			S_ERD: begin
				if (ent_i_q == cnt_q) begin
					if (act_q == stl_pkg::ACT_GET_KEY) begin
						r_status_q <= stl_pkg::ST_MISS;
					end else if (!key_zero) begin
						if (cnt_q >= CW'(KEYS_PER_SESSION)) begin
							r_status_q <= stl_pkg::ST_CAP;
						end else begin
							cnt_q <= cnt_q + CW'(1);
						end
					end
				end
			end
			S_ECHK: begin
				if (ent_match) begin
					if (act_q == stl_pkg::ACT_GET_KEY) begin
						r_found_q <= 1'b1;
						r_key_q   <= rd_key;
					end else if (key_zero) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end else begin
					ent_i_q <= ent_next;
				end
			end
			S_CWR: begin
				ent_i_q <= ent_next;
			end
			S_DONE: begin
				if (!rsp_valid || !rsp_stall) begin
					rsp.found       <= r_found_q;
					rsp.key_out     <= 64'(r_key_q);
					rsp.token_out   <= 64'(r_tok_q);
					rsp.account_out <= 64'(r_acc_q);
					rsp.status      <= r_status_q;
				end
			end
			default: begin
				ent_i_q <= ent_i_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			idx_q     <= '0;
			rsp_valid <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall && (state_q != S_DONE)) begin
				rsp_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					if (req_valid) begin
						if ((req.action > stl_pkg::ACT_CLEAR) ||
							(req.session_tag[TAG_BITS-1:0] == '0) ||
							(((req.action == stl_pkg::ACT_SET_KEY) ||
							(req.action == stl_pkg::ACT_GET_KEY)) &&
							(req.agent_tag[TAG_BITS-1:0] == '0))) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_SRD;
						end
					end
				end
				S_SRD: begin
					if (valid_q[idx_q]) begin
						state_q <= S_SCHK;
					end else if (last_slot) begin
						state_q <= S_MISS;
					end else begin
						idx_q <= idx_q + SW'(1);
					end
				end
				S_SCHK: begin
					if (cmp.expired) begin
						valid_q[idx_q] <= 1'b0;
						idx_q          <= idx_q + SW'(1);
						state_q        <= last_slot ? S_MISS : S_SRD;
					end else if (rd_tag == sess_q) begin
						case (act_q)
							stl_pkg::ACT_SET_KEY: state_q <= S_ERD;
							stl_pkg::ACT_GET_KEY: state_q <= S_ERD;
							stl_pkg::ACT_SET_TOKEN: state_q <= S_SWR;
							stl_pkg::ACT_GET_TOKEN: begin
								state_q <= (rd_tok != '0) ? S_SWR : S_DONE;
							end
							default: begin
								valid_q[idx_q] <= 1'b0;
								state_q        <= S_DONE;
							end
						endcase
					end else begin
						idx_q   <= idx_q + SW'(1);
						state_q <= last_slot ? S_MISS : S_SRD;
					end
				end
				S_MISS: begin
					case (act_q)
						stl_pkg::ACT_SET_KEY: state_q <= S_ERD;
						stl_pkg::ACT_SET_TOKEN: state_q <= S_SWR;
						default: state_q <= S_DONE;
					endcase
				end
				S_ERD: begin
					state_q <= (ent_i_q == cnt_q) ? S_SWR : S_ECHK;
				end
				S_ECHK: begin
					if (!ent_match) begin
						state_q <= S_ERD;
					end else if ((act_q == stl_pkg::ACT_SET_KEY) && key_zero &&
						(ent_next < cnt_q)) begin
						state_q <= S_CRD;
					end else begin
						state_q <= S_SWR;
					end
				end
				S_CRD: begin
					state_q <= S_CWR;
				end
				S_CWR: begin
					state_q <= (ent_next < cnt_q) ? S_CRD : S_SWR;
				end
				S_SWR: begin
					valid_q[slot_q] <= 1'b1;
					state_q         <= S_DONE;
				end
				S_DONE: begin
					if (!rsp_valid || !rsp_stall) begin
						rsp_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q != S_IDLE))
		else $error("accepted transaction left sequencer idle");

	a_slot_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWR) |=> valid_q[$past(slot_q)])
		else $error("written slot not marked valid");

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_ERD) || (state_q == S_ECHK) || (state_q == S_CWR)) |->
		(cnt_q <= CW'(KEYS_PER_SESSION)))
		else $error("key count above cap");

	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && !rsp_valid) |=> rsp_valid)
		else $error("response not issued from done state");

endmodule

// ===== tb/sv/session_table_ttl_lru_core_test.sv =====
// Self-checking testbench for session_table_ttl_lru_core: directed table, then random traffic.
// Depends on stl_pkg and the core; predicts every response with a behavioral session table.
module session_table_ttl_lru_core_test;

	localparam int NSESS = 256;
	localparam int NKEYS = 16;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_stall;
	stl_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_stall;
	stl_pkg::rsp_t rsp;
	logic          ttl_wr_en;
	logic [31:0]   ttl_wr_data;

	session_table_ttl_lru_core u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.ttl_wr_en(ttl_wr_en), .ttl_wr_data(ttl_wr_data)
	);

	// shadow table
	logic [31:0] ttl;
	bit          sv_valid [NSESS];
	logic [63:0] sv_tag [NSESS];
	logic [31:0] sv_last [NSESS];
	int          sv_count [NSESS];
	logic [63:0] sv_agent [NSESS][NKEYS];
	logic [63:0] sv_key [NSESS][NKEYS];
	logic [63:0] sv_token [NSESS];
	logic [63:0] sv_account [NSESS];

	stl_pkg::rsp_t pending_rsps[$];
	int   errors = 0;
	int   stall_left = 0;

	logic [63:0] tag_pool [12];
	logic [63:0] agent_pool [20];

	typedef struct {
		stl_pkg::req_t req;
		bit            has_exp;
		stl_pkg::rsp_t exp;
	} row_t;
	row_t rows[$];

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#50000000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic void wipe_session(int s);
		sv_valid[s] = 0;
		sv_tag[s] = 0;
		sv_last[s] = 0;
		sv_count[s] = 0;
		sv_token[s] = 0;
		sv_account[s] = 0;
		for (int i = 0; i < NKEYS; i++) begin
			sv_agent[s][i] = 0;
			sv_key[s][i] = 0;
		end
	endfunction

	function automatic int lookup_session(logic [63:0] tag, logic [31:0] now);
		longint idle;
		for (int s = 0; s < NSESS; s++) begin
			if (!sv_valid[s]) continue;
			idle = longint'({32'd0, now}) - longint'({32'd0, sv_last[s]});
			if (idle > longint'({32'd0, ttl})) begin
				wipe_session(s);
				continue;
			end
			if (sv_tag[s] == tag) return s;
		end
		return -1;
	endfunction

	function automatic int claim_session(logic [63:0] tag, logic [31:0] now);
		int hit;
		int pick;
		bit have_lru;
		hit = lookup_session(tag, now);
		pick = 0;
		have_lru = 0;
		if (hit >= 0) return hit;
		for (int s = 0; s < NSESS; s++) begin
			if (!sv_valid[s]) begin
				pick = s;
				break;
			end
			if (!have_lru || sv_last[s] < sv_last[pick]) begin
				pick = s;
				have_lru = 1;
			end
		end
		wipe_session(pick);
		sv_valid[pick] = 1;
		sv_tag[pick] = tag;
		sv_last[pick] = now;
		return pick;
	endfunction

	function automatic stl_pkg::rsp_t predict_session_op(stl_pkg::req_t r);
		stl_pkg::rsp_t o;
		int s;
		int i;
		int n;
		o = '0;
		o.status = stl_pkg::ST_OK;
		if (r.action > stl_pkg::ACT_CLEAR) begin
			o.status = stl_pkg::ST_MISS;
		end else if (r.session_tag == 0 ||
				((r.action == stl_pkg::ACT_SET_KEY || r.action == stl_pkg::ACT_GET_KEY) &&
				r.agent_tag == 0)) begin
			o.status = stl_pkg::ST_EMPTY;
		end else if (r.action == stl_pkg::ACT_SET_KEY) begin
			s = claim_session(r.session_tag, r.now);
			sv_last[s] = r.now;
			n = sv_count[s];
			for (i = 0; i < n; i++)
				if (sv_agent[s][i] == r.agent_tag) break;
			if (r.key_value == 0) begin
				if (i < n) begin
					for (; i + 1 < n; i++) begin
						sv_agent[s][i] = sv_agent[s][i + 1];
						sv_key[s][i] = sv_key[s][i + 1];
					end
					sv_agent[s][n - 1] = 0;
					sv_key[s][n - 1] = 0;
					sv_count[s] = n - 1;
				end
			end else if (i < n) begin
				sv_key[s][i] = r.key_value;
			end else if (n >= NKEYS) begin
				o.status = stl_pkg::ST_CAP;
			end else begin
				sv_agent[s][n] = r.agent_tag;
				sv_key[s][n] = r.key_value;
				sv_count[s] = n + 1;
			end
		end else if (r.action == stl_pkg::ACT_SET_TOKEN) begin
			s = claim_session(r.session_tag, r.now);
			sv_last[s] = r.now;
			sv_token[s] = r.token_value;
			sv_account[s] = r.account_value;
		end else if (r.action == stl_pkg::ACT_GET_KEY) begin
			s = lookup_session(r.session_tag, r.now);
			o.status = stl_pkg::ST_MISS;
			if (s >= 0) begin
				sv_last[s] = r.now;
				for (i = 0; i < sv_count[s]; i++) begin
					if (sv_agent[s][i] == r.agent_tag && sv_key[s][i] != 0) begin
						o.key_out = sv_key[s][i];
						o.found = 1;
						o.status = stl_pkg::ST_OK;
						break;
					end
				end
			end
		end else if (r.action == stl_pkg::ACT_GET_TOKEN) begin
			s = lookup_session(r.session_tag, r.now);
			o.status = stl_pkg::ST_MISS;
			if (s >= 0 && sv_token[s] != 0) begin
				sv_last[s] = r.now;
				o.token_out = sv_token[s];
				o.account_out = sv_account[s];
				o.found = 1;
				o.status = stl_pkg::ST_OK;
			end
		end else begin
			s = lookup_session(r.session_tag, r.now);
			if (s >= 0) wipe_session(s);
			else o.status = stl_pkg::ST_MISS;
		end
		return o;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 90) return $urandom_range(1, 3);
		if (p < 97) return $urandom_range(4, 20);
		return $urandom_range(50, 400);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic stl_pkg::req_t mk_req(logic [2:0] a, logic [31:0] now,
			logic [63:0] sess, logic [63:0] agent, logic [63:0] key, logic [63:0] tok,
			logic [63:0] acct);
		stl_pkg::req_t r;
		r.action = a;
		r.now = now;
		r.session_tag = sess;
		r.agent_tag = agent;
		r.key_value = key;
		r.token_value = tok;
		r.account_value = acct;
		return r;
	endfunction

	function automatic void add_row(stl_pkg::req_t r, bit has_exp, stl_pkg::rsp_t e);
		row_t w;
		w.req = r;
		w.has_exp = has_exp;
		w.exp = e;
		rows.push_back(w);
	endfunction

	function automatic stl_pkg::rsp_t mk_rsp(logic f, logic [63:0] k, logic [63:0] t,
			logic [63:0] a, logic [1:0] st);
		stl_pkg::rsp_t o;
		o.found = f;
		o.key_out = k;
		o.token_out = t;
		o.account_out = a;
		o.status = st;
		return o;
	endfunction

	task automatic send_req(stl_pkg::req_t r, bit has_exp, stl_pkg::rsp_t e);
		stl_pkg::rsp_t p;
		int g;
		g = gap_len();
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		p = predict_session_op(r);
		if (has_exp && p !== e) begin
			$display("%0t: table row disagrees with predictor expected=%h actual=%h",
				$time, e, p);
			errors++;
		end
		pending_rsps.push_back(p);
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	task automatic drain_and_idle();
		req_valid <= 1'b0;
		while (pending_rsps.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic write_ttl(logic [31:0] v);
		ttl_wr_en <= 1'b1;
		ttl_wr_data <= v;
		@(posedge clk);
		ttl_wr_en <= 1'b0;
		ttl = v;
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				rsp_stall <= 1'b1;
			end else if ($urandom_range(0, 99) < 25) begin
				rsp_stall <= 1'b1;
			end else if ($urandom_range(0, 199) == 0) begin
				stall_left = $urandom_range(20, 200);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		stl_pkg::rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsps.size() == 0) begin
				$display("%0t: unexpected response actual=%h", $time, rsp);
				errors++;
			end else begin
				e = pending_rsps.pop_front();
				if (rsp.found !== e.found || rsp.key_out !== e.key_out ||
						rsp.token_out !== e.token_out || rsp.account_out !== e.account_out ||
						rsp.status !== e.status) begin
					$display("%0t: mismatch expected=%h actual=%h", $time, e, rsp);
					errors++;
				end
			end
		end
	end

	initial begin
		stl_pkg::req_t r;
		logic [31:0] clock_s;
		int p;
		logic [2:0] a;
		logic [63:0] sess;
		logic [63:0] agent;
		logic [63:0] key;

		arst_n = 0;
		req_valid = 0;
		req = '0;
		rsp_stall = 0;
		ttl_wr_en = 0;
		ttl_wr_data = '0;
		ttl = stl_pkg::TTL_RESET;
		for (int s = 0; s < NSESS; s++) wipe_session(s);
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		add_row(mk_req(stl_pkg::ACT_GET_KEY, 32'd10, 64'd5, 64'd1, 0, 0, 0), 1,
			mk_rsp(0, 0, 0, 0, stl_pkg::ST_MISS));
		add_row(mk_req(stl_pkg::ACT_SET_KEY, 32'd10, 64'd0, 64'd1, 64'd9, 0, 0), 1,
			mk_rsp(0, 0, 0, 0, stl_pkg::ST_EMPTY));
		add_row(mk_req(stl_pkg::ACT_SET_KEY, 32'd10, 64'd5, 64'd0, 64'd9, 0, 0), 1,
			mk_rsp(0, 0, 0, 0, stl_pkg::ST_EMPTY));
		add_row(mk_req(3'd5, 32'd10, 64'd5, 64'd1, 0, 0, 0), 1,
			mk_rsp(0, 0, 0, 0, stl_pkg::ST_MISS));
		add_row(mk_req(3'd7, '1, '1, '1, '1, '1, '1), 1, mk_rsp(0, 0, 0, 0, stl_pkg::ST_MISS));
		add_row(mk_req(stl_pkg::ACT_CLEAR, 32'd10, 64'd5, 0, 0, 0, 0), 1,
			mk_rsp(0, 0, 0, 0, stl_pkg::ST_MISS));
		add_row(mk_req(stl_pkg::ACT_SET_KEY, 32'd20, '1, '1, '1, 0, 0), 1,
			mk_rsp(0, 0, 0, 0, stl_pkg::ST_OK));
		add_row(mk_req(stl_pkg::ACT_GET_KEY, 32'd21, '1, '1, 0, 0, 0), 1,
			mk_rsp(1, '1, 0, 0, stl_pkg::ST_OK));
		add_row(mk_req(stl_pkg::ACT_GET_TOKEN, 32'd22, '1, 0, 0, 0, 0), 1,
			mk_rsp(0, 0, 0, 0, stl_pkg::ST_MISS));
		add_row(mk_req(stl_pkg::ACT_SET_TOKEN, 32'd23, '1, 0, 0, '1, '1), 1,
			mk_rsp(0, 0, 0, 0, stl_pkg::ST_OK));
		add_row(mk_req(stl_pkg::ACT_GET_TOKEN, 32'd24, '1, 0, 0, 0, 0), 1,
			mk_rsp(1, 0, '1, '1, stl_pkg::ST_OK));
		for (int i = 1; i <= 17; i++)
			add_row(mk_req(stl_pkg::ACT_SET_KEY, 32'd30, 64'd77, 64'(i), 64'h100 + 64'(i),
				0, 0), 0, '0);
		add_row(mk_req(stl_pkg::ACT_SET_KEY, 32'd31, 64'd77, 64'd3, 64'd0, 0, 0), 0, '0);
		add_row(mk_req(stl_pkg::ACT_GET_KEY, 32'd32, 64'd77, 64'd16, 0, 0, 0), 0, '0);
		add_row(mk_req(stl_pkg::ACT_CLEAR, 32'd33, '1, 0, 0, 0, 0), 1,
			mk_rsp(0, 0, 0, 0, stl_pkg::ST_OK));
		foreach (rows[i]) send_req(rows[i].req, rows[i].has_exp, rows[i].exp);
		drain_and_idle();

		for (int i = 0; i < 12; i++)
			tag_pool[i] = (i < 2) ? {$urandom(), $urandom()} : 64'(i + 1);
		tag_pool[11] = '1;
		for (int i = 0; i < 20; i++) agent_pool[i] = (i == 19) ? '1 : rand64() | 64'd1;

		clock_s = 32'd1000;
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: write_ttl(32'd0);
				1: write_ttl(32'd40);
				2: write_ttl(32'hFFFF_FFFF);
				3: write_ttl(32'd7);
				default: write_ttl(stl_pkg::TTL_RESET);
			endcase
			for (int n = 0; n < 230; n++) begin
				p = $urandom_range(0, 99);
				if (p < 3) clock_s = clock_s - $urandom_range(0, 50);
				else if (p < 6) clock_s = $urandom();
				else clock_s = clock_s + $urandom_range(0, (phase == 1) ? 15 : 3);
				p = $urandom_range(0, 99);
				if (p < 3) a = 3'($urandom_range(5, 7));
				else if (p < 40) a = stl_pkg::ACT_SET_KEY;
				else if (p < 55) a = stl_pkg::ACT_SET_TOKEN;
				else if (p < 80) a = stl_pkg::ACT_GET_KEY;
				else if (p < 93) a = stl_pkg::ACT_GET_TOKEN;
				else a = stl_pkg::ACT_CLEAR;
				sess = ($urandom_range(0, 99) < 3) ? 64'd0 :
					($urandom_range(0, 99) < 5) ? rand64() : tag_pool[$urandom_range(0, 11)];
				agent = ($urandom_range(0, 99) < 3) ? 64'd0 :
					($urandom_range(0, 99) < 5) ? rand64() : agent_pool[$urandom_range(0, 19)];
				key = ($urandom_range(0, 99) < 15) ? 64'd0 : rand64();
				r = mk_req(a, clock_s, sess, agent, key,
					($urandom_range(0, 99) < 15) ? 64'd0 : rand64(),
					($urandom_range(0, 99) < 15) ? 64'd0 : rand64());
				send_req(r, 0, '0);
			end
			drain_and_idle();
		end

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

// ===== session_table_ttl_lru_core.f =====
rtl/core/stl_pkg.sv
rtl/core/stl_age_cmp.sv
rtl/core/session_table_ttl_lru_core.sv
tb/sv/session_table_ttl_lru_core_test.sv
